[sv/dcwa_pkg.sv]
package dcwa_pkg;

  // sample and mean width, 16 fraction bits
  localparam int SAMPLE_W      = 24;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE
  } state_t;

endpackage

[sv/dual_channel_window_average.sv]
// dual-channel moving average over a window of WINDOW_DEPTH samples
//
// input stream: one word per sample pair, voltage and current, both signed
// with 16 fraction bits. output stream: one word per input word carrying the
// mean of each window, same format, truncated toward zero. until the window
// has wrapped once the mean is taken over the samples written so far.
//
// timing: a word is taken only while the block is idle. the cycle after
// acceptance reads the oldest window entry and updates both running sums,
// then two bit-serial dividers work through all SUM_W quotient bits (SUM_W =
// 24 + log2 depth, 28 at depth 16). the result is loaded into the output
// register, and only after that does the block go idle and take a new word.
//
// the result sits in an output register; the next input word is taken while
// it waits. if the receiver stalls long enough the dividers hold their result
// and the block does not take further words until the output register frees.
//
// reset clears the position, the wrap flag and the sums. window memory is not
// cleared: before the first wrap the oldest entry counts as zero, so no clearing pass
module dual_channel_window_average import dcwa_pkg::*; #(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*SAMPLE_W-1:0] s_axis_tdata,  // [23:0] voltage_sample, [47:24] current_sample
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*SAMPLE_W-1:0] m_axis_tdata   // [23:0] mean_voltage, [47:24] mean_current
);

  localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  state_t state, state_next;

  // window position and wrap flag
  logic [POS_W-1:0] wr_pos;
  logic [POS_W-1:0] pos_next;
  logic             full;
  logic             full_next;
  logic [CNT_W-1:0] count;

  // captured samples
  logic signed [SAMPLE_W-1:0] v_smp;
  logic signed [SAMPLE_W-1:0] c_smp;

  // oldest entries leaving the window
  logic [2*SAMPLE_W-1:0]      rd_data;
  logic signed [SAMPLE_W-1:0] v_old;
  logic signed [SAMPLE_W-1:0] c_old;

  // running sums
  logic signed [SUM_W-1:0] v_sum, v_sum_next;
  logic signed [SUM_W-1:0] c_sum, c_sum_next;

  logic                accept;
  logic                div_start;
  logic                v_done;
  logic                c_done;
  logic [SAMPLE_W-1:0] v_mean;
  logic [SAMPLE_W-1:0] c_mean;
  logic                out_load;
  logic                out_free;

  assign accept    = s_axis_tvalid & s_axis_tready;
  assign div_start = (state == ST_LOAD);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // next write position wraps at the window depth
  assign pos_next  = (wr_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : wr_pos + POS_W'(1);
  assign full_next = full || (pos_next == '0);
  assign count     = full_next ? CNT_W'(WINDOW_DEPTH) : CNT_W'(pos_next);

  // before the first wrap the entry at wr_pos was never written: it counts as zero
  assign v_old = full ? rd_data[SAMPLE_W-1:0]          : '0;
  assign c_old = full ? rd_data[2*SAMPLE_W-1:SAMPLE_W] : '0;

  assign v_sum_next = v_sum + SUM_W'(v_smp) - SUM_W'(v_old);
  assign c_sum_next = c_sum + SUM_W'(c_smp) - SUM_W'(c_old);

  // both windows share one memory, voltage in the low half
  dcwa_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (POS_W)
  ) u_window (
    .clk   (clk),
    .we    (div_start),
    .waddr (wr_pos),
    .wdata ({c_smp, v_smp}),
    .re    (accept),
    .raddr (wr_pos),
    .rdata (rd_data)
  );

  dcwa_serdiv #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_v (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (v_sum_next),
    .divisor  (count),
    .done     (v_done),
    .quotient (v_mean)
  );

  dcwa_serdiv #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_c (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (c_sum_next),
    .divisor  (count),
    .done     (c_done),
    .quotient (c_mean)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (v_done && out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window bookkeeping, updated once per word in the load cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      full   <= 1'b0;
      v_sum  <= '0;
      c_sum  <= '0;
    end else if (div_start) begin
      wr_pos <= pos_next;
      full   <= full_next;
      v_sum  <= v_sum_next;
      c_sum  <= c_sum_next;
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (accept) begin
      v_smp <= s_axis_tdata[SAMPLE_W-1:0];
      c_smp <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {c_mean, v_mean};
    end
  end

`ifndef SYNTHESIS
  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    v_done == c_done)
    else $error("voltage and current dividers out of step");

  // an accepted word always goes to the load cycle next
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOAD))
    else $error("accepted word did not reach load cycle");

  // output only loads at the end of a division
  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DIVIDE && v_done))
    else $error("output loaded outside of division end");

  // write position stays inside the window
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    wr_pos <= POS_W'(WINDOW_DEPTH - 1))
    else $error("write position beyond window depth");
`endif

endmodule

[sv/dcwa_ram.sv]
module dcwa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/dcwa_serdiv.sv]
module dcwa_serdiv import dcwa_pkg::*; #(
  parameter int DIVIDEND_W = 28,
  parameter int DIVISOR_W  = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic [SAMPLE_W-1:0]          quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [DIVIDEND_W-1:0] q;
  logic                  neg;

  logic [DIVIDEND_W-1:0] mag;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] q_signed;

  // restoring division on the magnitude, one quotient bit per cycle
  assign mag      = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
  assign trial    = {rem, q[DIVIDEND_W-1]};
  assign diff     = trial - {1'b0, dvsr};
  assign ge       = (trial >= {1'b0, dvsr});
  assign rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  // sign applied after the fact gives truncation toward zero
  assign q_signed = neg ? DIVIDEND_W'(-q) : q;
  assign quotient = q_signed[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= STEP_W'(DIVIDEND_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - STEP_W'(1);
      if (cnt == STEP_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= mag;
      neg  <= dividend[DIVIDEND_W-1];
      dvsr <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      q   <= {q[DIVIDEND_W-2:0], ge};
    end
  end

endmodule
